[src/tfq_pkg.sv]
package tfq_pkg;

    // Configuration register widths and indexes.
    localparam int WIN_BITS  = 6;
    localparam int THR_BITS  = 16;
    localparam int PROD_BITS = THR_BITS + WIN_BITS;
    localparam int CFG_INDEX_BITS = 2;

    localparam logic [CFG_INDEX_BITS-1:0] REG_WINDOW_LENGTH = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_DROP_LIMIT    = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_FLAT_BAND     = 2'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_LEVEL_LIMIT   = 2'd3;

    localparam logic [WIN_BITS-1:0] WINDOW_LENGTH_RST = 6'd10;
    localparam logic [THR_BITS-1:0] DROP_LIMIT_RST    = 16'd118;
    localparam logic [THR_BITS-1:0] FLAT_BAND_RST     = 16'd0;
    localparam logic [THR_BITS-1:0] LEVEL_LIMIT_RST   = 16'd15073;

    // Window length is clamped to this range (and to the ring depth).
    localparam int WIN_MIN = 10;
    localparam int WIN_MAX = 50;

    // Command codes.
    localparam logic CMD_LOG    = 1'b0;
    localparam logic CMD_DETECT = 1'b1;

    // Error codes.
    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_DRAIN = 2'd1;
    localparam logic [1:0] ERR_FLAT  = 2'd2;

    // Debounce counter limits.
    localparam logic signed [2:0] PERS_CLEAR = -3'sd1;
    localparam logic signed [2:0] PERS_ZERO  = 3'sd0;
    localparam logic signed [2:0] PERS_ARMED = 3'sd1;
    localparam logic signed [2:0] PERS_TOP   = 3'sd2;

    typedef struct packed {
        logic log_en;
        logic restart;
        logic valve;
    } win_ctrl_t;

    typedef struct packed {
        logic full;
        logic at_least_n;
        logic any_open;
    } win_status_t;

endpackage

[src/tfq_window.sv]
module tfq_window #(
    parameter int RING_DEPTH = 64,
    parameter int LEVEL_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  tfq_pkg::win_ctrl_t            ctrl,
    input  logic [LEVEL_BITS-1:0]         level,
    input  logic [tfq_pkg::WIN_BITS-1:0]  win_n,
    input  logic [tfq_pkg::WIN_BITS-1:0]  win_n_next,
    output tfq_pkg::win_status_t          status,
    output logic [LEVEL_BITS-1:0]         newest,
    output logic [LEVEL_BITS-1:0]         oldest
);
    import tfq_pkg::*;

    localparam int AW = $clog2(RING_DEPTH);
    localparam int PW = (AW + 1 > WIN_BITS) ? AW + 1 : WIN_BITS;

    logic [LEVEL_BITS:0] ring_mem [RING_DEPTH];

    logic [AW-1:0]         wp_reg;
    logic [AW-1:0]         wp_next;
    logic [WIN_BITS-1:0]   count_reg;
    logic [WIN_BITS-1:0]   count_next;
    logic [WIN_BITS-1:0]   open_reg;
    logic [WIN_BITS-1:0]   open_next;
    logic [LEVEL_BITS-1:0] newest_reg;
    logic [LEVEL_BITS:0]   oldest_reg;
    logic [PW-1:0]         wp_ext;
    logic [PW-1:0]         n_ext;
    logic [PW-1:0]         rd_ext;
    logic [AW-1:0]         rd_addr;
    logic [WIN_BITS-1:0]   open_dropped;

    assign status.full       = (count_reg == win_n + WIN_BITS'(1));
    assign status.at_least_n = (count_reg >= win_n);
    assign status.any_open   = (open_reg != '0);
    assign newest = newest_reg;
    assign oldest = oldest_reg[LEVEL_BITS-1:0];

    always_comb
    begin
        if (ctrl.log_en) begin
            wp_next = (wp_reg == AW'(RING_DEPTH - 1)) ? '0 : wp_reg + AW'(1);
        end else begin
            wp_next = wp_reg;
        end
    end

    // The entry that is n samples behind the next write position is read ahead
    // of use, so it is already registered when the next word arrives.
    always_comb
    begin
        wp_ext = PW'(wp_next);
        n_ext  = PW'(win_n_next);
        if (wp_ext >= n_ext) begin
            rd_ext = wp_ext - n_ext;
        end else begin
            rd_ext = wp_ext + PW'(RING_DEPTH) - n_ext;
        end
        rd_addr = rd_ext[AW-1:0];
    end

    always_comb
    begin
        open_dropped = (status.at_least_n && oldest_reg[LEVEL_BITS]) ? WIN_BITS'(1) : '0;
        count_next = count_reg;
        open_next  = open_reg;
        if (ctrl.restart) begin
            count_next = '0;
            open_next  = '0;
        end else if (ctrl.log_en) begin
            open_next = open_reg - open_dropped + WIN_BITS'(ctrl.valve);
            if (count_reg <= win_n) begin
                count_next = count_reg + WIN_BITS'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wp_reg    <= '0;
            count_reg <= '0;
            open_reg  <= '0;
        end else begin
            wp_reg    <= wp_next;
            count_reg <= count_next;
            open_reg  <= open_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.log_en) begin
            ring_mem[wp_reg] <= {ctrl.valve, level};
            newest_reg       <= level;
        end
        oldest_reg <= ring_mem[rd_addr];
    end

endmodule

[src/tank_fault_qualifier_unit.sv]
// Tank fault qualifier. Each input word is either a log command, which stores a
// level sample and the inflow-valve bit in a sliding window of the last N
// samples (N = window_length clamped to 10..50 and to RING_DEPTH), or a detect
// command, which checks the draining and flat-with-valve-open faults over the
// window and debounces them with a persistence counter. Every input word gives
// exactly one result word. A word is accepted every cycle while the output is
// not stalled, and its result appears in the output register on the next
// cycle; the window memory has a single read port, and its oldest entry is
// fetched ahead of use. Writing window_length restarts the window fill; the
// memory needs no clearing pass after reset.
module tank_fault_qualifier_unit #(
    parameter int RING_DEPTH = 64,
    parameter int LEVEL_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                item_valid,
    output logic                                item_stall,
    input  logic                                command,
    input  logic [LEVEL_BITS-1:0]               level,
    input  logic                                valve_open,
    input  logic                                pump_on,
    output logic                                result_valid,
    input  logic                                result_stall,
    output logic [1:0]                          error_code,
    output logic                                window_full,
    input  logic                                cfg_write,
    input  logic [tfq_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [tfq_pkg::THR_BITS-1:0]        cfg_data
);
    import tfq_pkg::*;

    localparam logic [WIN_BITS-1:0] WIN_TOP =
        WIN_BITS'((RING_DEPTH < WIN_MAX) ? RING_DEPTH : WIN_MAX);
    localparam int CW = (LEVEL_BITS + 5 > PROD_BITS + 1) ? LEVEL_BITS + 5 : PROD_BITS + 1;

    function automatic logic [WIN_BITS-1:0] clamp_window(input logic [WIN_BITS-1:0] raw);
        logic [WIN_BITS-1:0] n;
        n = raw;
        if (n < WIN_BITS'(WIN_MIN)) begin
            n = WIN_BITS'(WIN_MIN);
        end
        if (n > WIN_TOP) begin
            n = WIN_TOP;
        end
        return n;
    endfunction

    logic [WIN_BITS-1:0] window_length_reg;
    logic [WIN_BITS-1:0] window_length_next;
    logic [THR_BITS-1:0] drop_limit_reg;
    logic [THR_BITS-1:0] flat_band_reg;
    logic [THR_BITS-1:0] level_limit_reg;

    logic signed [2:0]   persistence_reg;
    logic signed [2:0]   persistence_next;
    logic [1:0]          active_fault_reg;
    logic [1:0]          active_fault_next;

    logic                result_valid_reg;
    logic [1:0]          error_code_reg;
    logic                window_full_reg;
    logic [1:0]          code_next;
    logic                full_next;

    logic                accept;
    logic                detect_run;
    logic [WIN_BITS-1:0] win_n;
    logic [WIN_BITS-1:0] win_n_next;
    win_ctrl_t           win_ctrl;
    win_status_t         win_status;
    logic [LEVEL_BITS-1:0] newest_level;
    logic [LEVEL_BITS-1:0] oldest_level;

    logic signed [LEVEL_BITS:0] diff;
    logic signed [CW-1:0]       diff_ext;
    logic signed [CW-1:0]       diff_x10;
    logic signed [CW-1:0]       mag_x10;
    logic [PROD_BITS-1:0]       drop_prod;
    logic [PROD_BITS-1:0]       flat_prod;
    logic signed [CW-1:0]       drop_ext;
    logic signed [CW-1:0]       flat_ext;
    logic                       fault_drain;
    logic                       fault_flat;
    logic [1:0]                 seen;

    assign accept     = item_valid && !item_stall;
    assign item_stall = result_valid_reg && result_stall;

    assign window_length_next =
        (cfg_write && cfg_index == REG_WINDOW_LENGTH) ? cfg_data[WIN_BITS-1:0]
                                                      : window_length_reg;
    assign win_n      = clamp_window(window_length_reg);
    assign win_n_next = clamp_window(window_length_next);

    assign win_ctrl.log_en  = accept && (command == CMD_LOG);
    assign win_ctrl.restart = cfg_write && (cfg_index == REG_WINDOW_LENGTH);
    assign win_ctrl.valve   = valve_open;

    tfq_window #(
        .RING_DEPTH (RING_DEPTH),
        .LEVEL_BITS (LEVEL_BITS)
    ) u_window (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (win_ctrl),
        .level      (level),
        .win_n      (win_n),
        .win_n_next (win_n_next),
        .status     (win_status),
        .newest     (newest_level),
        .oldest     (oldest_level)
    );

    // Level change over the window, scaled by ten, against limit times N.
    always_comb
    begin
        diff      = $signed({1'b0, newest_level}) - $signed({1'b0, oldest_level});
        diff_ext  = {{(CW - LEVEL_BITS - 1){diff[LEVEL_BITS]}}, diff};
        diff_x10  = (diff_ext <<< 3) + (diff_ext <<< 1);
        mag_x10   = diff_x10[CW-1] ? -diff_x10 : diff_x10;
        drop_prod = PROD_BITS'(drop_limit_reg) * PROD_BITS'(win_n);
        flat_prod = PROD_BITS'(flat_band_reg) * PROD_BITS'(win_n);
        drop_ext  = $signed({{(CW - PROD_BITS){1'b0}}, drop_prod});
        flat_ext  = $signed({{(CW - PROD_BITS){1'b0}}, flat_prod});
        fault_drain = (-diff_x10 > drop_ext) && !win_status.any_open;
        fault_flat  = (mag_x10 <= flat_ext) && win_status.any_open && !pump_on
                      && ({{(CW - LEVEL_BITS){1'b0}}, level}
                          > {{(CW - THR_BITS){1'b0}}, level_limit_reg});
    end

    assign detect_run = accept && (command == CMD_DETECT) && win_status.full;

    always_comb
    begin
        persistence_next  = persistence_reg;
        active_fault_next = active_fault_reg;
        code_next         = ERR_NONE;
        seen              = fault_drain ? ERR_DRAIN : (fault_flat ? ERR_FLAT : ERR_NONE);
        if (detect_run) begin
            if (seen != ERR_NONE) begin
                if (active_fault_reg != ERR_NONE && active_fault_reg != seen) begin
                    // The other fault is latched; report it and leave the debounce alone.
                    code_next = active_fault_reg;
                end else if (persistence_reg == PERS_TOP) begin
                    code_next = seen;
                end else if (persistence_reg == PERS_ARMED) begin
                    persistence_next  = PERS_TOP;
                    active_fault_next = seen;
                    code_next         = seen;
                end else begin
                    persistence_next = persistence_reg + 3'sd1;
                end
            end else begin
                if (persistence_reg == PERS_ZERO) begin
                    active_fault_next = ERR_NONE;
                    persistence_next  = PERS_CLEAR;
                end else if (persistence_reg != PERS_CLEAR) begin
                    persistence_next = persistence_reg - 3'sd1;
                    code_next        = active_fault_reg;
                end
            end
        end
        full_next = (command == CMD_LOG) ? win_status.at_least_n : win_status.full;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            window_length_reg <= WINDOW_LENGTH_RST;
            drop_limit_reg    <= DROP_LIMIT_RST;
            flat_band_reg     <= FLAT_BAND_RST;
            level_limit_reg   <= LEVEL_LIMIT_RST;
        end else if (cfg_write) begin
            case (cfg_index)
                REG_WINDOW_LENGTH: window_length_reg <= cfg_data[WIN_BITS-1:0];
                REG_DROP_LIMIT:    drop_limit_reg    <= cfg_data;
                REG_FLAT_BAND:     flat_band_reg     <= cfg_data;
                REG_LEVEL_LIMIT:   level_limit_reg   <= cfg_data;
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            persistence_reg  <= PERS_CLEAR;
            active_fault_reg <= ERR_NONE;
            result_valid_reg <= 1'b0;
        end else begin
            persistence_reg  <= persistence_next;
            active_fault_reg <= active_fault_next;
            if (accept) begin
                result_valid_reg <= 1'b1;
            end else if (!result_stall) begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept) begin
            error_code_reg  <= code_next;
            window_full_reg <= full_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign error_code   = error_code_reg;
    assign window_full  = window_full_reg;

`ifndef SYNTHESIS
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> result_valid)
        else $error("accepted word did not produce a result word");

    a_no_code_unfilled: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !window_full |-> error_code == ERR_NONE)
        else $error("fault reported before the window filled");

    a_active_counted: assert property (@(posedge clk) disable iff (!rst_n)
        active_fault_reg != ERR_NONE |-> persistence_reg >= PERS_ZERO)
        else $error("latched fault with cleared persistence counter");

    a_top_latched: assert property (@(posedge clk) disable iff (!rst_n)
        persistence_reg == PERS_TOP |-> active_fault_reg != ERR_NONE)
        else $error("persistence saturated without a latched fault");
`endif

endmodule
